### rtl/char_lcd_bus_sequencer_macros.svh
// Assertion macros used by the back end of the character-LCD bus sequencer.
`ifndef CHAR_LCD_BUS_SEQUENCER_MACROS_SVH
`define CHAR_LCD_BUS_SEQUENCER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define LCD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lcd sequencer same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define LCD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lcd sequencer next-cycle check failed");
`else
`define LCD_ASSERT_IMP(label, clk, rstn, ante, cons)
`define LCD_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

### rtl/lcdseq_pkg.sv
// Types, constants and pin-step tables for the character-LCD bus sequencer.
package lcdseq_pkg;

    // Request codes carried on the input tuser.
    typedef enum logic [1:0] {
        OP_INIT = 2'd0,
        OP_CMD  = 2'd1,
        OP_CHAR = 2'd2,
        OP_GOTO = 2'd3
    } op_t;

    // Kinds of job the back end knows how to play out.
    typedef enum logic [1:0] {
        JOB_INIT8 = 2'd0,
        JOB_INIT4 = 2'd1,
        JOB_BYTE8 = 2'd2,
        JOB_BYTE4 = 2'd3
    } job_kind_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

    typedef struct packed {
        job_kind_t  kind;
        logic       rs;
        logic [7:0] value;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic       rs;
        logic       e;
        logic [7:0] data;
        logic [6:0] hold;
        logic       last;
    } step_t;

    localparam int          StepIdxW      = 5;
    localparam logic [6:0]  PowerWaitMs   = 7'd70;
    localparam logic [6:0]  Pulse8Ms      = 7'd2;
    localparam logic [6:0]  Pulse4Ms      = 7'd1;
    localparam logic [7:0]  GotoRow0Base  = 8'h80;
    localparam logic [7:0]  GotoRow1Base  = 8'hC0;
    localparam logic [7:0]  GotoMaxColumn = 8'd15;
    localparam logic [7:0]  GotoMaxRow    = 8'd1;
    localparam logic [StepIdxW-1:0] Init8LastIdx   = 5'd8;
    localparam logic [StepIdxW-1:0] Init4NibEndIdx = 5'd8;
    localparam logic [StepIdxW-1:0] Init4ByteIdx   = 5'd9;
    localparam logic [StepIdxW-1:0] Init4LastIdx   = 5'd28;

    // 8-bit init commands and their post delays.
    function automatic logic [7:0] init8_cmd(input logic [1:0] k);
        logic [7:0] c;
        unique case (k)
            2'd0: c = 8'h38;
            2'd1: c = 8'h0C;
            2'd2: c = 8'h01;
            default: c = 8'h06;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] init8_post(input logic [1:0] k);
        return (k == 2'd2) ? 7'd2 : 7'd1;
    endfunction

    // 4-bit init wake-up nibbles and their E-low delays.
    function automatic logic [7:0] init4_nib(input logic [1:0] n);
        return (n == 2'd3) ? 8'h20 : 8'h30;
    endfunction

    function automatic logic [6:0] init4_nib_post(input logic [1:0] n);
        return (n == 2'd0) ? 7'd8 : 7'd2;
    endfunction

    // 4-bit init two-nibble commands.
    function automatic logic [7:0] init4_cmd(input logic [2:0] j);
        logic [7:0] c;
        unique case (j)
            3'd0: c = 8'h28;
            3'd1: c = 8'h08;
            3'd2: c = 8'h01;
            3'd3: c = 8'h06;
            default: c = 8'h0C;
        endcase
        return c;
    endfunction

    // Pin step number idx of a job.
    function automatic step_t job_step(input job_t job, input logic [StepIdxW-1:0] idx);
        step_t s;
        logic [StepIdxW-1:0] b;
        logic [StepIdxW-1:0] b2;
        logic [7:0] cmd;
        b   = idx - 5'd1;
        b2  = idx - Init4ByteIdx;
        cmd = init4_cmd(b2[4:2]);
        s.rs   = job.rs;
        s.e    = ~idx[0];
        s.data = job.value;
        s.hold = 7'd0;
        s.last = 1'b0;
        unique case (job.kind)
            JOB_BYTE8: begin
                s.hold = idx[0] ? 7'd0 : Pulse8Ms;
                s.last = idx[0];
            end
            JOB_BYTE4: begin
                s.data = idx[1] ? {job.value[3:0], 4'h0} : {job.value[7:4], 4'h0};
                s.hold = idx[0] ? 7'd0 : Pulse4Ms;
                s.last = idx[1] & idx[0];
            end
            JOB_INIT8: begin
                s.rs = 1'b0;
                if (idx == '0) begin
                    s.e    = 1'b0;
                    s.data = 8'h00;
                    s.hold = PowerWaitMs;
                end else begin
                    s.e    = ~b[0];
                    s.data = init8_cmd(b[2:1]);
                    s.hold = b[0] ? init8_post(b[2:1]) : Pulse8Ms;
                end
                s.last = (idx == Init8LastIdx);
            end
            default: begin
                s.rs = 1'b0;
                if (idx == '0) begin
                    s.e    = 1'b0;
                    s.data = 8'h00;
                    s.hold = PowerWaitMs;
                end else if (idx <= Init4NibEndIdx) begin
                    s.e    = ~b[0];
                    s.data = init4_nib(b[2:1]);
                    s.hold = b[0] ? init4_nib_post(b[2:1]) : Pulse4Ms;
                end else begin
                    s.e    = ~b2[0];
                    s.data = b2[1] ? {cmd[3:0], 4'h0} : {cmd[7:4], 4'h0};
                    s.hold = b2[0] ? 7'd0 : Pulse4Ms;
                end
                s.last = (idx == Init4LastIdx);
            end
        endcase
        return s;
    endfunction

endpackage

### rtl/lcdseq_front.sv
// Front end: accepts requests, classifies them into jobs and drops bad gotos.
module lcdseq_front import lcdseq_pkg::*; (
    input  logic        bus_width_eight,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // value[7:0], column[15:8], row[23:16]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    input  q_status_t   q_stat,
    output logic        q_push,
    output job_t        q_job
);

    logic       keep;
    logic [7:0] value;
    logic [7:0] column;
    logic [7:0] row;
    job_kind_t  byte_kind;

    assign value     = s_tdata[7:0];
    assign column    = s_tdata[15:8];
    assign row       = s_tdata[23:16];
    assign byte_kind = bus_width_eight ? JOB_BYTE8 : JOB_BYTE4;

    // Map each request onto a job; an out-of-range goto produces none.
    always_comb begin
        keep        = 1'b1;
        q_job.kind  = byte_kind;
        q_job.rs    = 1'b0;
        q_job.value = value;
        unique case (op_t'(s_tuser))
            OP_INIT: begin
                q_job.kind  = bus_width_eight ? JOB_INIT8 : JOB_INIT4;
                q_job.value = 8'h00;
            end
            OP_CMD: begin
                q_job.rs = 1'b0;
            end
            OP_CHAR: begin
                q_job.rs = 1'b1;
            end
            default: begin
                keep        = (column <= GotoMaxColumn) && (row <= GotoMaxRow);
                q_job.value = (row[0] ? GotoRow1Base : GotoRow0Base) + {4'h0, column[3:0]};
            end
        endcase
    end

    assign s_tready = ~q_stat.full;
    assign q_push   = s_tvalid & s_tready & keep;

endmodule

### rtl/lcdseq_fifo.sv
// Short job queue between the front and back ends.
module lcdseq_fifo import lcdseq_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head_job,
    output q_status_t stat
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    job_t            mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign stat.full  = (count_reg == CntW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push & ~stat.full;
    assign do_pop     = pop & ~stat.empty;
    assign head_job   = mem[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/lcdseq_back.sv
// Back end: plays each job out as pin steps through an output register.
`include "char_lcd_bus_sequencer_macros.svh"
module lcdseq_back import lcdseq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  job_t        q_head,
    input  q_status_t   q_stat,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_write[0], enable[1], bus_data[9:2], hold_ms[16:10]
    output logic [0:0]  m_tuser,   // reg_select[0]
    output logic        m_tlast
);

    back_state_t         state_reg;
    back_state_t         state_next;
    job_t                job_reg;
    logic [StepIdxW-1:0] idx_reg;
    logic                out_valid_reg;
    step_t               out_step_reg;
    step_t               step;
    logic                out_free;
    logic                load;

    assign step     = job_step(job_reg, idx_reg);
    assign out_free = ~out_valid_reg | m_tready;

    // Sequencer: take a job when idle, then one step per free output slot.
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop      = 1'b1;
                    state_next = BK_RUN;
                end
            end
            default: begin
                if (out_free) begin
                    load = 1'b1;
                    if (step.last) begin
                        state_next = BK_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                idx_reg <= '0;
            end else if (load) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Current job payload.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_head;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_step_reg <= step;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {7'd0, out_step_reg.hold, out_step_reg.data, out_step_reg.e, 1'b0};
    assign m_tuser[0] = out_step_reg.rs;
    assign m_tlast    = out_step_reg.last;

    // A job is only taken while no other job is playing out.
    `LCD_ASSERT_IMP(a_pop_when_idle, aclk, aresetn, q_pop, state_reg == BK_IDLE)
    // The final step of a job returns the sequencer to idle.
    `LCD_ASSERT_NXT(a_last_ends_job, aclk, aresetn, load && step.last, state_reg == BK_IDLE)
    // The step counter never runs past the longest job.
    `LCD_ASSERT_IMP(a_idx_bound, aclk, aresetn, state_reg == BK_RUN, idx_reg <= Init4LastIdx)

endmodule

### rtl/char_lcd_bus_sequencer.sv
// Top level of the character-LCD bus sequencer: config register, front, queue, back.
//
//  Channel   Direction  Handshake             Carries
//  s_        in         s_tvalid / s_tready   one request (operation, value, column, row)
//  m_        out        m_tvalid / m_tready   one pin step (rs, rw, e, data, hold, last)
//  APB       in         psel & penable        bus_width_eight at address 0
//
// A request plays out as 2 or 4 steps (byte), 9 or 29 steps (init), one step per cycle
// while m_tready allows, after the back end has taken the job from the queue while idle.
// A goto out of range is dropped in the front end and produces no step.
// The queue holds QUEUE_DEPTH jobs; s_tready falls only when it is full.
// The output register lets a step wait on m_tready while the next one is prepared.
// Reset is synchronous on aresetn and clears the register, queue and sequencer.
module char_lcd_bus_sequencer import lcdseq_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // value[7:0], column[15:8], row[23:16]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_write[0], enable[1], bus_data[9:2], hold_ms[16:10]
    output logic [0:0]  m_tuser,   // reg_select[0]
    output logic        m_tlast
);

    logic      bus_width_eight_reg;
    logic      reg_hit;
    q_status_t q_stat;
    logic      q_push;
    logic      q_pop;
    job_t      q_job;
    job_t      q_head;

    // Configuration register.
    assign pready  = 1'b1;
    assign reg_hit = (paddr == 2'd0);
    assign prdata  = {31'd0, bus_width_eight_reg & reg_hit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_width_eight_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            bus_width_eight_reg <= pwdata[0];
        end
    end

    lcdseq_front u_front (
        .bus_width_eight (bus_width_eight_reg),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .q_stat          (q_stat),
        .q_push          (q_push),
        .q_job           (q_job)
    );

    lcdseq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head_job (q_head),
        .stat     (q_stat)
    );

    lcdseq_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### tb/lcd_step_checker.sv
// Checker that predicts the pin steps of each accepted request and compares the result stream.
`timescale 1ns / 1ps
module lcd_step_checker import lcdseq_pkg::*; #(
    parameter logic [1:0] BusWidthAddr = 2'd0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // value[7:0], column[15:8], row[23:16]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // read_write[0], enable[1], bus_data[9:2], hold_ms[16:10]
    input  logic [0:0]  m_tuser,   // reg_select[0]
    input  logic        m_tlast,
    input  logic        run_done,
    output int          mismatch_count,
    output int          pending_steps
);

    typedef struct {
        logic       rs;
        logic       rw;
        logic       e;
        logic [7:0] data;
        logic [6:0] hold;
        logic       last;
    } pin_step_t;

    pin_step_t expected_steps[$];
    logic      bus_eight;
    int        error_total;
    bit        leftovers_checked;

    // One mismatch: print a line and count it.
    task automatic report_mismatch(input string msg);
        error_total++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function automatic void add_step(input logic rs, input logic e, input logic [7:0] data,
                                     input logic [6:0] hold);
        pin_step_t st;
        st.rs   = rs;
        st.rw   = 1'b0;
        st.e    = e;
        st.data = data;
        st.hold = hold;
        st.last = 1'b0;
        expected_steps.push_back(st);
    endfunction

    // A single E pulse on the nibble bus; only the upper four bits are driven.
    function automatic void add_nibble(input logic rs, input logic [7:0] nib,
                                       input logic [6:0] high_hold, input logic [6:0] low_hold);
        add_step(rs, 1'b1, {nib[7:4], 4'h0}, high_hold);
        add_step(rs, 1'b0, {nib[7:4], 4'h0}, low_hold);
    endfunction

    // A whole byte: one 2 ms pulse on the wide bus, or two 1 ms nibble pulses.
    function automatic void add_byte(input logic rs, input logic [7:0] b, input logic [6:0] post);
        if (bus_eight) begin
            add_step(rs, 1'b1, b, Pulse8Ms);
            add_step(rs, 1'b0, b, post);
        end else begin
            add_nibble(rs, b, Pulse4Ms, 7'd0);
            add_nibble(rs, {b[3:0], 4'h0}, Pulse4Ms, post);
        end
    endfunction

    // Queue the pin steps that one request should produce, marking the final one.
    function automatic void predict_pin_steps(input op_t op, input logic [7:0] value,
                                              input logic [7:0] column, input logic [7:0] row);
        int        first;
        pin_step_t tail;
        first = expected_steps.size();
        unique case (op)
            OP_INIT: begin
                add_step(1'b0, 1'b0, 8'h00, PowerWaitMs);
                if (bus_eight) begin
                    // Function set, display on, clear, entry mode.
                    add_byte(1'b0, 8'h38, 7'd1);
                    add_byte(1'b0, 8'h0C, 7'd1);
                    add_byte(1'b0, 8'h01, 7'd2);
                    add_byte(1'b0, 8'h06, 7'd1);
                end else begin
                    // Wake-up nibbles, then switch to 4-bit and configure.
                    add_nibble(1'b0, 8'h30, Pulse4Ms, 7'd8);
                    add_nibble(1'b0, 8'h30, Pulse4Ms, 7'd2);
                    add_nibble(1'b0, 8'h30, Pulse4Ms, 7'd2);
                    add_nibble(1'b0, 8'h20, Pulse4Ms, 7'd2);
                    add_byte(1'b0, 8'h28, 7'd0);
                    add_byte(1'b0, 8'h08, 7'd0);
                    add_byte(1'b0, 8'h01, 7'd0);
                    add_byte(1'b0, 8'h06, 7'd0);
                    add_byte(1'b0, 8'h0C, 7'd0);
                end
            end
            OP_CMD:  add_byte(1'b0, value, 7'd0);
            OP_CHAR: add_byte(1'b1, value, 7'd0);
            OP_GOTO: begin
                // Positions off the two-line, sixteen-column screen are dropped.
                if (column <= GotoMaxColumn && row <= GotoMaxRow) begin
                    add_byte(1'b0, ((row != 8'd0) ? GotoRow1Base : GotoRow0Base) + column, 7'd0);
                end
            end
            default: ;
        endcase
        if (expected_steps.size() > first) begin
            tail = expected_steps.pop_back();
            tail.last = 1'b1;
            expected_steps.push_back(tail);
        end
    endfunction

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    // Compare one accepted pin step with the oldest expectation.
    task automatic check_pin_step();
        pin_step_t want;
        if (expected_steps.size() == 0) begin
            report_mismatch($sformatf("step with nothing expected, tdata %h", m_tdata));
        end else begin
            want = expected_steps.pop_front();
            compare_field("reg_select", {7'd0, m_tuser[0]}, {7'd0, want.rs});
            compare_field("read_write", {7'd0, m_tdata[0]}, {7'd0, want.rw});
            compare_field("enable", {7'd0, m_tdata[1]}, {7'd0, want.e});
            compare_field("bus_data", m_tdata[9:2], want.data);
            compare_field("hold_ms", {1'b0, m_tdata[16:10]}, {1'b0, want.hold});
            compare_field("last", {7'd0, m_tlast}, {7'd0, want.last});
            compare_field("tdata padding", {1'b0, m_tdata[23:17]}, 8'd0);
        end
    endtask

    // Track the bus width register, predict on each request, check on each step.
    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_steps.delete();
            bus_eight = 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == BusWidthAddr) begin
                bus_eight = pwdata[0];
            end
            if (s_tvalid && s_tready) begin
                predict_pin_steps(op_t'(s_tuser), s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
            end
            if (m_tvalid && m_tready) begin
                check_pin_step();
            end
            if (run_done && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                while (expected_steps.size() != 0) begin
                    void'(expected_steps.pop_front());
                    report_mismatch("expected step never arrived");
                end
            end
        end
        pending_steps  <= expected_steps.size();
        mismatch_count <= error_total;
    end

endmodule

### tb/tb_top.sv
// Testbench top for the character-LCD bus sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top import lcdseq_pkg::*; ();

    localparam logic [1:0] BusWidthAddr     = 2'd0;
    localparam int         SettleCycles     = 64;
    localparam int         RandomPhaseItems = 75;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [1:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        run_done = 1'b0;
    logic        steady   = 1'b0;
    int          mismatch_count;
    int          pending_steps;

    char_lcd_bus_sequencer dut (.*);

    lcd_step_checker #(.BusWidthAddr(BusWidthAddr)) step_check (.*);

    always #4 aclk = ~aclk;

    // The receiver stalls about a quarter of the time, except in the steady stretch.
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 26);
    end

    // Stop sending and let every expected step drain out of the block.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_steps != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    // Setup and access phase of a bus width write.
    task automatic write_bus_width(input logic eight);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BusWidthAddr;
        pwdata  <= {31'd0, eight};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one request, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_request(input op_t op, input logic [7:0] value,
                                input logic [7:0] column, input logic [7:0] row);
        if (!steady) begin
            while ($urandom_range(0, 99) < 26) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {row, column, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Mostly byte requests and on-screen gotos; now and then an init or an off-screen goto.
    task automatic send_random();
        op_t        op;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] value;
        int         pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 6) begin
            op = OP_INIT;
        end else if (pick < 40) begin
            op = OP_CMD;
        end else if (pick < 72) begin
            op = OP_CHAR;
        end else begin
            op = OP_GOTO;
        end
        column = 8'($urandom_range(0, 255));
        row    = 8'($urandom_range(0, 255));
        value  = 8'($urandom_range(0, 255));
        if (op == OP_GOTO && $urandom_range(0, 99) < 75) begin
            column = 8'($urandom_range(0, 15));
            row    = 8'($urandom_range(0, 1));
        end
        send_request(op, value, column, row);
    endtask

    initial begin
        int phase;
        int k;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items on the nibble bus, the reset setting.
        send_request(OP_INIT, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_CMD, 8'h00, 8'h00, 8'h00);
        send_request(OP_CMD, 8'hFF, 8'hAA, 8'h55);
        send_request(OP_CMD, 8'hA5, 8'h00, 8'h00);
        send_request(OP_CHAR, 8'h00, 8'hFF, 8'hFF);
        send_request(OP_CHAR, 8'hFF, 8'h00, 8'h00);
        send_request(OP_CHAR, 8'h5A, 8'h00, 8'h00);
        send_request(OP_GOTO, 8'hFF, 8'd0, 8'd0);
        send_request(OP_GOTO, 8'h00, 8'd15, 8'd0);
        send_request(OP_GOTO, 8'h00, 8'd0, 8'd1);
        send_request(OP_GOTO, 8'h00, 8'd15, 8'd1);
        send_request(OP_GOTO, 8'h00, 8'd16, 8'd0);
        send_request(OP_GOTO, 8'h00, 8'd0, 8'd2);
        send_request(OP_GOTO, 8'h00, 8'd255, 8'd255);
        send_request(OP_GOTO, 8'h00, 8'd7, 8'd1);

        // Directed items on the full byte bus.
        wait_idle();
        write_bus_width(1'b1);
        send_request(OP_INIT, 8'h00, 8'h00, 8'h00);
        send_request(OP_CMD, 8'hFF, 8'h00, 8'h00);
        send_request(OP_CHAR, 8'h00, 8'h00, 8'h00);
        send_request(OP_GOTO, 8'h00, 8'd15, 8'd1);
        send_request(OP_GOTO, 8'h00, 8'd15, 8'd2);
        send_request(OP_GOTO, 8'h00, 8'd0, 8'd0);

        // Random phases, alternating the bus width; part of one phase runs without idling.
        for (phase = 0; phase < 4; phase++) begin
            wait_idle();
            write_bus_width(phase[0]);
            for (k = 0; k < RandomPhaseItems; k++) begin
                steady <= (phase == 2 && k >= 15 && k < 55);
                send_random();
            end
        end

        wait_idle();
        run_done <= 1'b1;
        repeat (2) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
